// File: rtl/rlp_pkg.sv
// rlp_pkg: types, codes and helpers for the http request line parser
// depends on nothing; imported by the interfaces and every rtl module

package rlp_pkg;

    localparam int OFS_W = 13;

    // packed method characters, first character in the low byte
    localparam logic [31:0] METHOD_GET  = 32'h0054_4547;
    localparam logic [31:0] METHOD_POST = 32'h5453_4F50;
    localparam logic [31:0] METHOD_HEAD = 32'h4441_4548;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;

    typedef enum logic [3:0] {
        PH_START,
        PH_METHOD,
        PH_SP_BEFORE_URI,
        PH_URI,
        PH_HTTP,
        PH_H,
        PH_HT,
        PH_HTT,
        PH_HTTP_SLASH,
        PH_FIRST_MAJOR,
        PH_MAJOR,
        PH_FIRST_MINOR,
        PH_MINOR,
        PH_SP_AFTER,
        PH_ALMOST
    } t_phase;

    typedef enum logic [1:0] {
        ST_AGAIN,
        ST_DONE,
        ST_BAD_METHOD,
        ST_BAD_REQUEST
    } t_status;

    typedef enum logic [1:0] {
        MK_UNKNOWN,
        MK_GET,
        MK_POST,
        MK_HEAD
    } t_method;

    // per-line parse state, positions are kept in the top level
    typedef struct packed {
        t_phase      phase;
        logic [31:0] method_chars;
        logic [2:0]  method_len;
        t_method     method_kind;
        logic [7:0]  major_acc;
        logic [7:0]  minor_acc;
        logic        cr_seen;
    } t_parse_state;

    localparam t_parse_state LINE_CLEAR = '{
        phase:        PH_START,
        method_chars: 32'h0,
        method_len:   3'd0,
        method_kind:  MK_UNKNOWN,
        major_acc:    8'd0,
        minor_acc:    8'd0,
        cr_seen:      1'b0
    };

    // position capture strobes and status from the parse logic
    typedef struct packed {
        t_status status;
        logic    cap_start;
        logic    cap_method_end;
        logic    cap_uri_begin;
        logic    cap_uri_finish;
        logic    cap_cr;
    } t_step_ctl;

    typedef struct packed {
        t_status          status;
        t_method          method_code;
        logic [7:0]       major_version;
        logic [7:0]       minor_version;
        logic [OFS_W-1:0] line_start_offset;
        logic [OFS_W-1:0] method_end_offset;
        logic [OFS_W-1:0] uri_start_offset;
        logic [OFS_W-1:0] uri_end_offset;
        logic [OFS_W-1:0] line_end_offset;
    } t_result;

    function automatic logic is_method_char(input logic [7:0] c);
        return ((c >= CH_UPA) && (c <= CH_UPZ)) || (c == CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // acc * 10 + digit, held at 255
    function automatic logic [7:0] sat_digit(input logic [7:0] acc, input logic [7:0] c);
        logic [11:0] v;
        v = ({4'b0, acc} * 12'd10) + {8'b0, c[3:0]};
        return (v > 12'd255) ? 8'd255 : v[7:0];
    endfunction

endpackage

// File: rtl/rlp_if.sv
// rlp_if: valid/ready channels for request bytes and parse results
// depends on rlp_pkg

interface rlp_byte_if import rlp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface rlp_result_if import rlp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [1:0]       method_code;
    logic [7:0]       major_version;
    logic [7:0]       minor_version;
    logic [OFS_W-1:0] line_start_offset;
    logic [OFS_W-1:0] method_end_offset;
    logic [OFS_W-1:0] uri_start_offset;
    logic [OFS_W-1:0] uri_end_offset;
    logic [OFS_W-1:0] line_end_offset;

    modport source (
        output valid, output status, output method_code,
        output major_version, output minor_version,
        output line_start_offset, output method_end_offset,
        output uri_start_offset, output uri_end_offset, output line_end_offset,
        input ready
    );
    modport sink (
        input valid, input status, input method_code,
        input major_version, input minor_version,
        input line_start_offset, input method_end_offset,
        input uri_start_offset, input uri_end_offset, input line_end_offset,
        output ready
    );
endinterface

// File: rtl/rlp_fsm.sv
// rlp_fsm: next-state logic of the request line state machine for one byte
// depends on rlp_pkg

module rlp_fsm import rlp_pkg::*; (
    input  t_parse_state i_state,
    input  logic [7:0]   i_data,
    output t_parse_state o_next,
    output t_step_ctl    o_ctl
);

    t_parse_state n_state;
    t_step_ctl    ctl;
    logic [2:0]   len;

    assign len = i_state.method_len;

    always_comb begin
        n_state = i_state;
        ctl     = '{status: ST_AGAIN, default: 1'b0};

        unique case (i_state.phase)
            PH_START: begin
                ctl.cap_start = 1'b1;
                if ((i_data == CH_CR) || (i_data == CH_LF)) begin
                    n_state = i_state;
                end else if (!is_method_char(i_data)) begin
                    ctl.status = ST_BAD_METHOD;
                end else begin
                    n_state.method_chars[{len[1:0], 3'b000} +: 8] = i_data;
                    n_state.method_len = len + 3'd1;
                    n_state.phase = PH_METHOD;
                end
            end
            PH_METHOD: begin
                if (i_data == CH_SPACE) begin
                    ctl.cap_method_end = 1'b1;
                    n_state.phase = PH_SP_BEFORE_URI;
                    if ((len == 3'd3) && (i_state.method_chars[23:0] == METHOD_GET[23:0])) begin
                        n_state.method_kind = MK_GET;
                    end else if ((len == 3'd4) && (i_state.method_chars == METHOD_POST)) begin
                        n_state.method_kind = MK_POST;
                    end else if ((len == 3'd4) && (i_state.method_chars == METHOD_HEAD)) begin
                        n_state.method_kind = MK_HEAD;
                    end else begin
                        n_state.method_kind = MK_UNKNOWN;
                    end
                end else if (is_method_char(i_data)) begin
                    // only the first four characters are kept
                    if (len < 3'd4) begin
                        n_state.method_chars[{len[1:0], 3'b000} +: 8] = i_data;
                    end
                    if (len != 3'd7) begin
                        n_state.method_len = len + 3'd1;
                    end
                end else begin
                    ctl.status = ST_BAD_METHOD;
                end
            end
            PH_SP_BEFORE_URI: begin
                if (i_data == CH_SLASH) begin
                    ctl.cap_uri_begin = 1'b1;
                    n_state.phase = PH_URI;
                end else if (i_data != CH_SPACE) begin
                    ctl.status = ST_BAD_REQUEST;
                end
            end
            PH_URI: begin
                if (i_data == CH_SPACE) begin
                    ctl.cap_uri_finish = 1'b1;
                    n_state.phase = PH_HTTP;
                end
            end
            PH_HTTP: begin
                if (i_data == CH_H) begin
                    n_state.phase = PH_H;
                end else if (i_data != CH_SPACE) begin
                    ctl.status = ST_BAD_REQUEST;
                end
            end
            PH_H: begin
                if (i_data == CH_T) n_state.phase = PH_HT;
                else ctl.status = ST_BAD_REQUEST;
            end
            PH_HT: begin
                if (i_data == CH_T) n_state.phase = PH_HTT;
                else ctl.status = ST_BAD_REQUEST;
            end
            PH_HTT: begin
                if (i_data == CH_P) n_state.phase = PH_HTTP_SLASH;
                else ctl.status = ST_BAD_REQUEST;
            end
            PH_HTTP_SLASH: begin
                if (i_data == CH_SLASH) n_state.phase = PH_FIRST_MAJOR;
                else ctl.status = ST_BAD_REQUEST;
            end
            PH_FIRST_MAJOR: begin
                if ((i_data >= CH_ONE) && (i_data <= CH_NINE)) begin
                    n_state.major_acc = {4'b0, i_data[3:0]};
                    n_state.phase = PH_MAJOR;
                end else begin
                    ctl.status = ST_BAD_REQUEST;
                end
            end
            PH_MAJOR: begin
                if (i_data == CH_DOT) begin
                    n_state.phase = PH_FIRST_MINOR;
                end else if (is_digit(i_data)) begin
                    n_state.major_acc = sat_digit(i_state.major_acc, i_data);
                end else begin
                    ctl.status = ST_BAD_REQUEST;
                end
            end
            PH_FIRST_MINOR: begin
                if (is_digit(i_data)) begin
                    n_state.minor_acc = {4'b0, i_data[3:0]};
                    n_state.phase = PH_MINOR;
                end else begin
                    ctl.status = ST_BAD_REQUEST;
                end
            end
            PH_MINOR, PH_SP_AFTER: begin
                if (i_data == CH_CR) begin
                    ctl.cap_cr = 1'b1;
                    n_state.cr_seen = 1'b1;
                    n_state.phase = PH_ALMOST;
                end else if (i_data == CH_LF) begin
                    ctl.status = ST_DONE;
                end else if (i_data == CH_SPACE) begin
                    n_state.phase = PH_SP_AFTER;
                end else if ((i_state.phase == PH_MINOR) && is_digit(i_data)) begin
                    n_state.minor_acc = sat_digit(i_state.minor_acc, i_data);
                end else begin
                    ctl.status = ST_BAD_REQUEST;
                end
            end
            PH_ALMOST: begin
                if (i_data == CH_LF) ctl.status = ST_DONE;
                else ctl.status = ST_BAD_REQUEST;
            end
            default: begin
                n_state.phase = PH_START;
            end
        endcase

        // completion or error starts a fresh line
        if (ctl.status != ST_AGAIN) begin
            n_state = LINE_CLEAR;
        end
    end

    assign o_next = n_state;
    assign o_ctl  = ctl;

endmodule

// File: rtl/rlp_out_stage.sv
// rlp_out_stage: result register that holds a word until the sink takes it
// depends on rlp_pkg and rlp_result_if

module rlp_out_stage import rlp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_can_load,
    rlp_result_if.source o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_data;

    // free when empty or the held word leaves this cycle
    assign o_can_load = !r_valid || o_result.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_result.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_result.valid             = r_valid;
    assign o_result.status            = r_data.status;
    assign o_result.method_code       = r_data.method_code;
    assign o_result.major_version     = r_data.major_version;
    assign o_result.minor_version     = r_data.minor_version;
    assign o_result.line_start_offset = r_data.line_start_offset;
    assign o_result.method_end_offset = r_data.method_end_offset;
    assign o_result.uri_start_offset  = r_data.uri_start_offset;
    assign o_result.uri_end_offset    = r_data.uri_end_offset;
    assign o_result.line_end_offset   = r_data.line_end_offset;

endmodule

// File: rtl/http_request_line_parser.sv
// http_request_line_parser: result word valid in the cycle after byte accept
// 1 byte/cycle unless stalled, set by the single registered parse step and result register
// one result word per byte; a held result stops the next byte unless the sink takes it
// synchronous active-low reset: start phase, byte position 0, result register empty
// depends on rlp_pkg, rlp_if, rlp_fsm, rlp_out_stage

module http_request_line_parser import rlp_pkg::*; #(
    parameter int BUF_DEPTH = 8192
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rlp_byte_if.sink     i_byte,
    rlp_result_if.source o_result
);

    // position counter width follows the buffer depth
    localparam int PW = $clog2(BUF_DEPTH);
    localparam logic [PW-1:0] PosLast = PW'(BUF_DEPTH - 1);

    logic         accept;
    logic         can_load;

    t_parse_state r_state;
    t_parse_state n_state;
    t_step_ctl    step_ctl;

    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;

    // captured offsets of the line parts
    logic [PW-1:0] r_start_pos;
    logic [PW-1:0] r_method_end_pos;
    logic [PW-1:0] r_uri_begin_pos;
    logic [PW-1:0] r_uri_finish_pos;
    logic [PW-1:0] r_cr_pos;
    logic [PW-1:0] line_end;

    t_result       result;

    // a byte goes in whenever the result register can take its word
    assign i_byte.ready = can_load;
    assign accept       = i_byte.valid && can_load;

    rlp_fsm u_fsm (
        .i_state (r_state),
        .i_data  (i_byte.data_byte),
        .o_next  (n_state),
        .o_ctl   (step_ctl)
    );

    // byte position wraps at the buffer depth, any depth in range
    assign n_pos = (r_pos == PosLast) ? '0 : r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LINE_CLEAR;
            r_pos   <= '0;
        end else if (accept) begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    // offset registers only matter once their part of the line was seen
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (step_ctl.cap_start)      r_start_pos      <= r_pos;
            if (step_ctl.cap_method_end) r_method_end_pos <= r_pos;
            if (step_ctl.cap_uri_begin)  r_uri_begin_pos  <= r_pos;
            if (step_ctl.cap_uri_finish) r_uri_finish_pos <= r_pos;
            if (step_ctl.cap_cr)         r_cr_pos         <= r_pos;
        end
    end

    // line end is the cr when one came, else the lf itself
    assign line_end = r_state.cr_seen ? r_cr_pos : r_pos;

    // every field but status reads zero unless the line completes
    always_comb begin
        result        = '0;
        result.status = step_ctl.status;
        if (step_ctl.status == ST_DONE) begin
            result.method_code       = r_state.method_kind;
            result.major_version     = r_state.major_acc;
            result.minor_version     = r_state.minor_acc;
            result.line_start_offset = OFS_W'(r_start_pos);
            result.method_end_offset = OFS_W'(r_method_end_pos);
            result.uri_start_offset  = OFS_W'(r_uri_begin_pos);
            result.uri_end_offset    = OFS_W'(r_uri_finish_pos);
            result.line_end_offset   = OFS_W'(line_end);
        end
    end

    rlp_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_result   (result),
        .o_can_load (can_load),
        .o_result   (o_result)
    );

endmodule
